// ===== rtl/color_window_region_key_detector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Color window region key detector - assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COLOR_WINDOW_REGION_KEY_DETECTOR_UNIT_MACROS_SVH
`define COLOR_WINDOW_REGION_KEY_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CWRK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CWRK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cwrk_pkg.sv =====
// ----------------------------------------------------------------------------
// Color window region key detector - shared package
// Field widths, reset values, register codes and the payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package cwrk_pkg;

   localparam int CHAN_W      = 8;
   localparam int REGION_W    = 3;
   localparam int COUNT_W     = 10;
   localparam int SUM_W       = 18;
   localparam int MASK_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam int REGION_COUNT_DEF  = 8;
   localparam int REGION_PIXELS_DEF = 600;

   localparam logic [CHAN_W-1:0]  TOL_CH0_RST    = 8'd30;
   localparam logic [CHAN_W-1:0]  TOL_CH1_RST    = 8'd40;
   localparam logic [CHAN_W-1:0]  TOL_CH2_RST    = 8'd50;
   localparam logic [COUNT_W-1:0] MIN_HITS_RST   = 10'd300;
   localparam logic [CHAN_W-1:0]  CENTER_CH0_RST = 8'd10;
   localparam logic [CHAN_W-1:0]  CENTER_CH1_RST = 8'd0;
   localparam logic [CHAN_W-1:0]  CENTER_CH2_RST = 8'd0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [CHAN_W-1:0]  CHAN_MAX  = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOL_CH0  = 3'd0,
      CSR_TOL_CH1  = 3'd1,
      CSR_TOL_CH2  = 3'd2,
      CSR_MIN_HITS = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   chan0;
      logic [CHAN_W-1:0]   chan1;
      logic [CHAN_W-1:0]   chan2;
      logic [REGION_W-1:0] region;
      logic                frame_end;
      logic                calibrate;
   } req_payload_type;

   typedef struct packed {
      logic [MASK_W-1:0] key_mask;
      logic [CHAN_W-1:0] center_ch0;
      logic [CHAN_W-1:0] center_ch1;
      logic [CHAN_W-1:0] center_ch2;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  tol_ch0;
      logic [CHAN_W-1:0]  tol_ch1;
      logic [CHAN_W-1:0]  tol_ch2;
      logic [COUNT_W-1:0] min_hits;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] ch0;
      logic [CHAN_W-1:0] ch1;
      logic [CHAN_W-1:0] ch2;
   } center_type;

   // One classified pixel waiting between the front and the back.
   typedef struct packed {
      logic [CHAN_W-1:0]   chan0;
      logic [CHAN_W-1:0]   chan1;
      logic [CHAN_W-1:0]   chan2;
      logic [REGION_W-1:0] region;
      logic                in_range;
      logic                hit;
      logic                frame_end;
      logic                calibrate;
   } queue_entry_type;

   typedef struct packed {
      center_type centers;
      logic       cal_done;
   } back_status_type;

   // Strict window test c - t < v < c + t, rearranged so that nothing goes negative.
   function automatic logic in_window(input logic [CHAN_W-1:0] value,
                                      input logic [CHAN_W-1:0] center,
                                      input logic [CHAN_W-1:0] tol);
      logic [CHAN_W:0] v;
      logic [CHAN_W:0] c;
      logic [CHAN_W:0] t;
      v = {1'b0, value};
      c = {1'b0, center};
      t = {1'b0, tol};
      return (v < c + t) && (v + t > c);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cwrk_front.sv =====
// ----------------------------------------------------------------------------
// Color window region key detector - front end
// Accepts pixel requests, judges the color window and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cwrk_front #(
   parameter int REGION_COUNT = cwrk_pkg::REGION_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cwrk_pkg::req_payload_type req_payload,
   input  cwrk_pkg::cfg_type         cfg,
   input  cwrk_pkg::back_status_type status,
   input  logic                      q_full,
   output logic                      q_push,
   output cwrk_pkg::queue_entry_type q_entry
);

   import cwrk_pkg::*;

   logic cal_pending_ff;
   logic cal_pending_in;

   // A calibrating frame end holds further requests until the back end has
   // loaded the new centers, so later pixels are judged against them.
   assign req_stall = q_full || cal_pending_ff;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      q_entry.chan0     = req_payload.chan0;
      q_entry.chan1     = req_payload.chan1;
      q_entry.chan2     = req_payload.chan2;
      q_entry.region    = req_payload.region;
      q_entry.in_range  = int'(req_payload.region) < REGION_COUNT;
      q_entry.hit       = in_window(req_payload.chan0, status.centers.ch0, cfg.tol_ch0) &&
                          in_window(req_payload.chan1, status.centers.ch1, cfg.tol_ch1) &&
                          in_window(req_payload.chan2, status.centers.ch2, cfg.tol_ch2);
      q_entry.frame_end = req_payload.frame_end;
      q_entry.calibrate = req_payload.frame_end && req_payload.calibrate;
   end

   always_comb begin
      cal_pending_in = cal_pending_ff;
      if (status.cal_done) begin
         cal_pending_in = 1'b0;
      end
      if (q_push && q_entry.calibrate) begin
         cal_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_pending_ff <= 1'b0;
      end else begin
         cal_pending_ff <= cal_pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cwrk_queue.sv =====
// ----------------------------------------------------------------------------
// Color window region key detector - pixel queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cwrk_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cwrk_pkg::queue_entry_type push_entry,
   input  logic                      pop,
   output cwrk_pkg::queue_entry_type head_entry,
   output logic                      empty,
   output logic                      full
);

   import cwrk_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [COUNT_W-1:0]   count_ff;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cwrk_back.sv =====
// ----------------------------------------------------------------------------
// Color window region key detector - back end
// Counts hits per region, sums region 0, forms the key mask and recalibrates.
// ----------------------------------------------------------------------------
`default_nettype none

module cwrk_back #(
   parameter int REGION_COUNT  = cwrk_pkg::REGION_COUNT_DEF,
   parameter int REGION_PIXELS = cwrk_pkg::REGION_PIXELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  cwrk_pkg::queue_entry_type   head_entry,
   output logic                        pop,
   input  logic [cwrk_pkg::COUNT_W-1:0] min_hits,
   output cwrk_pkg::back_status_type   status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cwrk_pkg::rsp_payload_type   rsp_payload
);

   import cwrk_pkg::*;

   // The mean is a multiplication by a rounded-up reciprocal of the pixel
   // count. With the shift set to the sum width plus the bits of the pixel
   // count, the truncated product equals the truncated quotient for every sum.
   localparam int     DIV_SHIFT  = SUM_W + $clog2(REGION_PIXELS);
   localparam int     RECIP_W    = SUM_W + 1;
   localparam int     PROD_W     = SUM_W + RECIP_W;
   localparam longint RECIP_FULL = ((longint'(1) << DIV_SHIFT) +
                                    longint'(REGION_PIXELS) - longint'(1)) /
                                   longint'(REGION_PIXELS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIVIDE,
      ST_REPORT
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   count_ff [REGION_COUNT];
   logic [COUNT_W-1:0]   count_in [REGION_COUNT];
   logic [SUM_W-1:0]     sum_ff   [3];
   logic [SUM_W-1:0]     sum_in   [3];
   logic [CHAN_W-1:0]    center_ff [3];
   logic [CHAN_W-1:0]    center_new [3];
   logic [SUM_W-1:0]     quot_ff  [3];
   logic [SUM_W-1:0]     quot_in  [3];
   logic [MASK_W-1:0]    mask_ff;
   logic [MASK_W-1:0]    mask_in;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_payload_ff;
   logic                 cal_done_ff;
   logic                 out_free;
   logic                 rsp_load;
   logic [CHAN_W-1:0]    head_chan [3];
   logic                 head_region0;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_RUN) && head_valid &&
                     (!head_entry.frame_end || out_free);

   // A response is loaded on a plain frame end or at the end of a calibration.
   assign rsp_load = ((state_ff == ST_RUN) && pop && head_entry.frame_end &&
                      !head_entry.calibrate) ||
                     ((state_ff == ST_REPORT) && out_free);

   assign head_chan[0] = head_entry.chan0;
   assign head_chan[1] = head_entry.chan1;
   assign head_chan[2] = head_entry.chan2;
   assign head_region0 = head_entry.in_range && (head_entry.region == '0);

   // Counts and sums as they stand once the head pixel is taken in.
   always_comb begin
      for (int i = 0; i < REGION_COUNT; i++) begin
         count_in[i] = count_ff[i];
         if (head_entry.in_range && head_entry.hit && (int'(head_entry.region) == i) &&
             (count_ff[i] != COUNT_MAX)) begin
            count_in[i] = count_ff[i] + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      logic [SUM_W:0] wide;
      for (int c = 0; c < 3; c++) begin
         wide      = {1'b0, sum_ff[c]} + (SUM_W + 1)'(head_chan[c]);
         sum_in[c] = sum_ff[c];
         if (head_region0) begin
            sum_in[c] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
         end
      end
   end

   // Region 0 lands on bit REGION_COUNT-1 of the mask, its most significant bit when REGION_COUNT equals MASK_W.
   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (REGION_COUNT - 1 - b >= 0) begin : g_bit
         assign mask_in[b] = count_in[REGION_COUNT-1-b] > min_hits;
      end else begin : g_pad
         assign mask_in[b] = 1'b0;
      end
   end

   // quot_ff holds the frame sums until the divide clock replaces them with
   // the means; a mean above the channel range is clamped.
   always_comb begin
      logic [PROD_W-1:0] product;
      for (int c = 0; c < 3; c++) begin
         product       = PROD_W'(quot_ff[c]) * PROD_W'(RECIP);
         quot_in[c]    = SUM_W'(product >> DIV_SHIFT);
         center_new[c] = (|quot_ff[c][SUM_W-1:CHAN_W]) ? CHAN_MAX : quot_ff[c][CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
         cal_done_ff  <= 1'b0;
         for (int i = 0; i < REGION_COUNT; i++) begin
            count_ff[i] <= '0;
         end
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= '0;
         end
         center_ff[0] <= CENTER_CH0_RST;
         center_ff[1] <= CENTER_CH1_RST;
         center_ff[2] <= CENTER_CH2_RST;
      end else begin
         cal_done_ff <= (state_ff == ST_REPORT) && out_free;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (pop) begin
                  if (head_entry.frame_end) begin
                     for (int i = 0; i < REGION_COUNT; i++) begin
                        count_ff[i] <= '0;
                     end
                     for (int c = 0; c < 3; c++) begin
                        sum_ff[c] <= '0;
                     end
                     if (head_entry.calibrate) begin
                        mask_ff <= mask_in;
                        for (int c = 0; c < 3; c++) begin
                           quot_ff[c] <= sum_in[c];
                        end
                        state_ff <= ST_DIVIDE;
                     end else begin
                        rsp_payload_ff.key_mask   <= mask_in;
                        rsp_payload_ff.center_ch0 <= center_ff[0];
                        rsp_payload_ff.center_ch1 <= center_ff[1];
                        rsp_payload_ff.center_ch2 <= center_ff[2];
                     end
                  end else begin
                     count_ff <= count_in;
                     sum_ff   <= sum_in;
                  end
               end
            end
            ST_DIVIDE: begin
               quot_ff  <= quot_in;
               state_ff <= ST_REPORT;
            end
            ST_REPORT: begin
               if (out_free) begin
                  center_ff                 <= center_new;
                  rsp_payload_ff.key_mask   <= mask_ff;
                  rsp_payload_ff.center_ch0 <= center_new[0];
                  rsp_payload_ff.center_ch1 <= center_new[1];
                  rsp_payload_ff.center_ch2 <= center_new[2];
                  state_ff                  <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign status.centers.ch0 = center_ff[0];
   assign status.centers.ch1 = center_ff[1];
   assign status.centers.ch2 = center_ff[2];
   assign status.cal_done    = cal_done_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/color_window_region_key_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Color window region key detector - top level
// Per-region color window hit counter that reports a key mask once per frame.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while req_stall is low and
// returns one response per frame, on the frame-end pixel. The response is
// registered once that pixel has passed through the queue and been popped by
// the back end, which waits for a free response side. A pixel counts as a hit
// for its region when all three channels lie strictly inside center plus or
// minus tolerance; a region's key bit is set when its hit count exceeds
// min_hits. On a frame end with calibrate set, the centers are reloaded with
// the truncated mean of that frame's region 0 pixels, found by multiplying
// with the reciprocal of the pixel count in a divide state and then a report
// state that waits for a free response side. While that calibration runs,
// requests are stalled; all other pixels flow at one per clock through a
// four-entry queue while it is not full. Configuration writes are always
// ready and must only be made while the block is idle.
`default_nettype none
`include "color_window_region_key_detector_unit_macros.svh"

module color_window_region_key_detector_unit #(
   parameter int REGION_COUNT  = cwrk_pkg::REGION_COUNT_DEF,
   parameter int REGION_PIXELS = cwrk_pkg::REGION_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Pixel requests.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cwrk_pkg::req_payload_type       req_payload,
   // Per-frame responses.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cwrk_pkg::rsp_payload_type       rsp_payload,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cwrk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cwrk_pkg::CSR_DATA_W-1:0]  csr_data
);

   import cwrk_pkg::*;

   cfg_type          cfg_ff;
   back_status_type  status;
   queue_entry_type  q_entry;
   queue_entry_type  q_head;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   logic             plain_frame_pop;

   // The register file takes a write on any clock.
   assign csr_ready = 1'b1;

   // Unknown register indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tol_ch0  <= TOL_CH0_RST;
         cfg_ff.tol_ch1  <= TOL_CH1_RST;
         cfg_ff.tol_ch2  <= TOL_CH2_RST;
         cfg_ff.min_hits <= MIN_HITS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOL_CH0:  cfg_ff.tol_ch0  <= csr_data[CHAN_W-1:0];
            CSR_TOL_CH1:  cfg_ff.tol_ch1  <= csr_data[CHAN_W-1:0];
            CSR_TOL_CH2:  cfg_ff.tol_ch2  <= csr_data[CHAN_W-1:0];
            CSR_MIN_HITS: cfg_ff.min_hits <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each pixel against the current centers.
   cwrk_front #(
      .REGION_COUNT (REGION_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .status      (status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // The queue lets the front keep taking pixels while a response waits.
   cwrk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // The back end accumulates, forms the mask and runs the calibration divide.
   cwrk_back #(
      .REGION_COUNT  (REGION_COUNT),
      .REGION_PIXELS (REGION_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!q_empty),
      .head_entry  (q_head),
      .pop         (q_pop),
      .min_hits    (cfg_ff.min_hits),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A frame end without calibration leaves the queue.
   assign plain_frame_pop = q_pop && q_head.frame_end && !q_head.calibrate;

   // The queue is never written while full nor read while empty.
   `CWRK_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_push, !q_full, "queue overflow")
   `CWRK_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, q_pop, !q_empty, "queue underflow")
   // A plain frame end always yields a response on the next clock.
   `CWRK_ASSERT_NEXT(a_frame_end_response, clock, reset, plain_frame_pop, rsp_valid, "no response")

endmodule

`default_nettype wire
